// ----- rtl/tesp_pkg.sv -----
`default_nettype none

package tesp_pkg;

   localparam int MODE_BITS  = 24;
   localparam int HASH_BYTES = 20;
   localparam int INDEX_BITS = 16;
   localparam int HASH_CNT_BITS = $clog2(HASH_BYTES);

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_SEVEN = 8'h37;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef enum logic [3:0] {
      PHASE_MODE = 4'b0001,
      PHASE_NAME = 4'b0010,
      PHASE_HASH = 4'b0100,
      PHASE_DROP = 4'b1000
   } phase_type;

   typedef enum logic [2:0] {
      KIND_MODE      = 3'd0,
      KIND_NAME_BYTE = 3'd1,
      KIND_NAME_END  = 3'd2,
      KIND_HASH_BYTE = 3'd3,
      KIND_ERROR     = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ERR_END_IN_MODE = 2'd0,
      ERR_NO_SPACE    = 2'd1,
      ERR_END_IN_NAME = 2'd2,
      ERR_END_IN_HASH = 2'd3
   } err_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       buffer_end;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] entry_number;
      logic [23:0] mode_value;
      logic [7:0]  data_byte;
      logic [6:0]  hex_high;
      logic [6:0]  hex_low;
      logic        entry_done;
      err_type     error_code;
   } rsp_type;

   typedef struct packed {
      phase_type                phase;
      logic [MODE_BITS-1:0]     mode_acc;
      logic [HASH_CNT_BITS-1:0] hash_cnt;
      logic [INDEX_BITS-1:0]    entry_cnt;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:     PHASE_MODE,
      mode_acc:  '0,
      hash_cnt:  '0,
      entry_cnt: INDEX_BITS'(1)
   };

   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      logic [6:0] c;
      if (nib < 4'd10) begin
         c = 7'h30 + 7'(nib);
      end else begin
         c = 7'h57 + 7'(nib);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/tesp_step.sv -----
`default_nettype none

module tesp_step (
   input  var tesp_pkg::state_type state,
   input  var tesp_pkg::req_type   req,
   output var tesp_pkg::state_type state_next,
   output logic                    has_rsp,
   output var tesp_pkg::rsp_type   rsp
);
   import tesp_pkg::*;

   logic                   last;
   logic                   is_digit;
   logic [MODE_BITS+2:0]   mode_sum;
   logic [MODE_BITS-1:0]   mode_new;
   logic                   final_hash;
   rsp_type                base;

   assign last     = req.buffer_end;
   assign is_digit = (req.in_byte >= CHAR_ZERO) && (req.in_byte <= CHAR_SEVEN);
   assign mode_sum = {state.mode_acc, 3'b000} + (MODE_BITS + 3)'(req.in_byte[2:0]);
   assign mode_new = (|mode_sum[MODE_BITS+2:MODE_BITS]) ? '1 : mode_sum[MODE_BITS-1:0];
   assign final_hash = (state.hash_cnt == HASH_CNT_BITS'(HASH_BYTES - 1));

   always_comb begin
      base = '0;
      base.entry_number = 16'(state.entry_cnt);
   end

   always_comb begin
      state_next = state;
      has_rsp    = 1'b0;
      rsp        = base;
      unique case (state.phase)
         PHASE_MODE: begin
            if (is_digit) begin
               if (last) begin
                  has_rsp        = 1'b1;
                  rsp.kind       = KIND_ERROR;
                  rsp.error_code = ERR_END_IN_MODE;
                  state_next     = STATE_RESET;
               end else begin
                  state_next.mode_acc = mode_new;
               end
            end else if (req.in_byte != CHAR_SPACE) begin
               has_rsp        = 1'b1;
               rsp.kind       = KIND_ERROR;
               rsp.error_code = ERR_NO_SPACE;
               if (last) begin
                  state_next = STATE_RESET;
               end else begin
                  state_next.phase = PHASE_DROP;
               end
            end else if (last) begin
               has_rsp        = 1'b1;
               rsp.kind       = KIND_ERROR;
               rsp.error_code = ERR_END_IN_NAME;
               state_next     = STATE_RESET;
            end else begin
               has_rsp          = 1'b1;
               rsp.kind         = KIND_MODE;
               rsp.mode_value   = 24'(state.mode_acc);
               state_next.phase = PHASE_NAME;
            end
         end
         PHASE_NAME: begin
            has_rsp = 1'b1;
            if (req.in_byte != 8'h00) begin
               if (last) begin
                  rsp.kind       = KIND_ERROR;
                  rsp.error_code = ERR_END_IN_NAME;
                  state_next     = STATE_RESET;
               end else begin
                  rsp.kind      = KIND_NAME_BYTE;
                  rsp.data_byte = req.in_byte;
               end
            end else if (last) begin
               rsp.kind       = KIND_ERROR;
               rsp.error_code = ERR_END_IN_HASH;
               state_next     = STATE_RESET;
            end else begin
               rsp.kind            = KIND_NAME_END;
               state_next.phase    = PHASE_HASH;
               state_next.hash_cnt = '0;
            end
         end
         PHASE_HASH: begin
            has_rsp = 1'b1;
            if (final_hash || !last) begin
               rsp.kind       = KIND_HASH_BYTE;
               rsp.data_byte  = req.in_byte;
               rsp.hex_high   = hex_char(req.in_byte[7:4]);
               rsp.hex_low    = hex_char(req.in_byte[3:0]);
               rsp.entry_done = final_hash;
            end else begin
               rsp.kind       = KIND_ERROR;
               rsp.error_code = ERR_END_IN_HASH;
            end
            if (last) begin
               state_next = STATE_RESET;
            end else if (final_hash) begin
               state_next.phase     = PHASE_MODE;
               state_next.mode_acc  = '0;
               state_next.hash_cnt  = '0;
               state_next.entry_cnt = state.entry_cnt + INDEX_BITS'(1);
            end else begin
               state_next.hash_cnt = state.hash_cnt + HASH_CNT_BITS'(1);
            end
         end
         PHASE_DROP: begin
            if (last) begin
               state_next = STATE_RESET;
            end
         end
         default: begin
            state_next = STATE_RESET;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/tree_entry_stream_parser.sv -----
// Tree entry stream parser.
// The req channel carries one word per byte of a tree object: the byte and a
// flag that marks the last byte of the buffer. The rsp channel carries at most
// one result word per input byte: the finished mode, each name byte, the end
// of the name, each hash byte with its two hex characters, or an error.
// Both channels use valid and ready.
// Each byte is parsed in the cycle in which it is accepted, and its result is
// shown on the rsp port from the next cycle.
// One byte is taken in every cycle while the receiver keeps up; the single result register is the only
// stage, and it is refilled in the same cycle in which its word is taken.
// When the receiver stalls, req_ready falls while a result waits, so input
// is held off until that word has gone.
// Bytes that give no result (mode digits, dropped bytes) are taken even
// while a result waits.
// Reset returns the parser to the start of an entry with the entry count
// at one and empties the result register; the same restart happens after
// every buffer's last byte.
`default_nettype none

module tree_entry_stream_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  var tesp_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output var tesp_pkg::rsp_type rsp_data
);
   import tesp_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_ff;
   rsp_type   step_rsp;
   logic      step_has_rsp;
   logic      accept;

   tesp_step u_step (
      .state      (state_ff),
      .req        (req_data),
      .state_next (state_in),
      .has_rsp    (step_has_rsp),
      .rsp        (step_rsp)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready || !step_has_rsp;
   assign accept    = req_valid && req_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && step_has_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && step_has_rsp) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_restart_on_last: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.buffer_end |=> state_ff.phase == PHASE_MODE
         && state_ff.entry_cnt == INDEX_BITS'(1) && state_ff.mode_acc == '0)
      else $error("parser did not restart after the last byte of a buffer");

   a_hash_count_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.hash_cnt <= HASH_CNT_BITS'(HASH_BYTES - 1))
      else $error("hash byte count out of range");

   a_done_on_hash: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.entry_done |-> rsp_ff.kind == KIND_HASH_BYTE)
      else $error("entry end marked on a word that is not a hash byte");

   a_drop_holds: assert property (@(posedge clock) disable iff (reset)
      accept && !req_data.buffer_end && state_ff.phase == PHASE_DROP
         |=> state_ff.phase == PHASE_DROP)
      else $error("drop phase left before the end of the buffer");

   a_no_lost_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready && accept |-> !step_has_rsp)
      else $error("result word overwritten while stalled");

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import tesp_pkg::*;

   localparam int WORD_TARGET    = 1550;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam logic [7:0] NAME_END_BYTE = 8'h00;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type    byte_queue[$];
   rsp_type    expected_results[$];
   logic [7:0] entry_bytes[$];

   phase_type             parse_phase;
   logic [MODE_BITS-1:0]  mode_acc;
   int unsigned           hash_count;
   logic [INDEX_BITS-1:0] entry_count;

   int    send_idle_pct  = 0;
   int    recv_stall_pct = 0;
   int    fail_count     = 0;
   int    words_queued   = 0;
   int    words_taken    = 0;
   int    results_seen   = 0;
   int    entries_done   = 0;
   int    errors_seen    = 0;
   int    idle_cycles    = 0;
   string hex_digits     = "0123456789abcdef";

   always #4 clock = ~clock;

   tree_entry_stream_parser i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   function automatic void restart_parse();
      parse_phase = PHASE_MODE;
      mode_acc    = '0;
      hash_count  = 0;
      entry_count = INDEX_BITS'(1);
   endfunction

   function automatic rsp_type blank_result(kind_type k);
      rsp_type r;
      r              = '0;
      r.kind         = k;
      r.entry_number = entry_count;
      return r;
   endfunction

   function automatic rsp_type hash_result(logic [7:0] b, logic done);
      rsp_type r;
      r            = blank_result(KIND_HASH_BYTE);
      r.data_byte  = b;
      r.hex_high   = 7'(hex_digits[b[7:4]]);
      r.hex_low    = 7'(hex_digits[b[3:0]]);
      r.entry_done = done;
      return r;
   endfunction

   function automatic void report_error(err_type code, logic last);
      rsp_type r;
      r            = blank_result(KIND_ERROR);
      r.error_code = code;
      expected_results.push_back(r);
      if (last) begin
         restart_parse();
      end else begin
         parse_phase = PHASE_DROP;
      end
   endfunction

   function automatic void parse_byte(req_type w);
      logic [7:0]      b;
      logic            last;
      longint unsigned digit;
      longint unsigned mode_max;
      rsp_type         r;
      b        = w.in_byte;
      last     = w.buffer_end;
      mode_max = (64'd1 << MODE_BITS) - 1;
      case (parse_phase)
         PHASE_MODE: begin
            if (b >= CHAR_ZERO && b <= CHAR_SEVEN) begin
               if (last) begin
                  report_error(ERR_END_IN_MODE, 1'b1);
               end else begin
                  digit = b - CHAR_ZERO;
                  if (mode_acc > (mode_max - digit) / 8) begin
                     mode_acc = mode_max;
                  end else begin
                     mode_acc = MODE_BITS'(mode_acc * 8 + digit);
                  end
               end
            end else if (b != CHAR_SPACE) begin
               report_error(ERR_NO_SPACE, last);
            end else if (last) begin
               report_error(ERR_END_IN_NAME, 1'b1);
            end else begin
               r            = blank_result(KIND_MODE);
               r.mode_value = mode_acc;
               expected_results.push_back(r);
               parse_phase = PHASE_NAME;
            end
         end
         PHASE_NAME: begin
            if (b != NAME_END_BYTE) begin
               if (last) begin
                  report_error(ERR_END_IN_NAME, 1'b1);
               end else begin
                  r           = blank_result(KIND_NAME_BYTE);
                  r.data_byte = b;
                  expected_results.push_back(r);
               end
            end else if (last) begin
               report_error(ERR_END_IN_HASH, 1'b1);
            end else begin
               expected_results.push_back(blank_result(KIND_NAME_END));
               parse_phase = PHASE_HASH;
               hash_count  = 0;
            end
         end
         PHASE_HASH: begin
            if (hash_count + 1 >= HASH_BYTES) begin
               expected_results.push_back(hash_result(b, 1'b1));
               if (last) begin
                  restart_parse();
               end else begin
                  parse_phase = PHASE_MODE;
                  mode_acc    = '0;
                  hash_count  = 0;
                  entry_count = entry_count + 1'b1;
               end
            end else if (last) begin
               report_error(ERR_END_IN_HASH, 1'b1);
            end else begin
               hash_count++;
               expected_results.push_back(hash_result(b, 1'b0));
            end
         end
         default: begin
            if (last) begin
               restart_parse();
            end
         end
      endcase
   endfunction

   function automatic void check_field(string field, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         fail_count++;
      end
   endfunction

   function automatic void check_result(rsp_type want, rsp_type got);
      check_field("kind", want.kind, got.kind);
      check_field("entry_number", want.entry_number, got.entry_number);
      check_field("mode_value", want.mode_value, got.mode_value);
      check_field("data_byte", want.data_byte, got.data_byte);
      check_field("hex_high", want.hex_high, got.hex_high);
      check_field("hex_low", want.hex_low, got.hex_low);
      check_field("entry_done", want.entry_done, got.entry_done);
      check_field("error_code", want.error_code, got.error_code);
   endfunction

   function automatic void push_word(logic [7:0] b, logic last);
      req_type w;
      w.in_byte    = b;
      w.buffer_end = last;
      byte_queue.push_back(w);
      words_queued++;
   endfunction

   function automatic void add_entry();
      int n_digits;
      int n_name;
      n_digits = ($urandom_range(0, 99) < 15) ? $urandom_range(8, 11) : $urandom_range(0, 6);
      n_name   = $urandom_range(0, 6);
      repeat (n_digits) entry_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 7)));
      entry_bytes.push_back(CHAR_SPACE);
      repeat (n_name) entry_bytes.push_back(8'($urandom_range(1, 255)));
      entry_bytes.push_back(NAME_END_BYTE);
      repeat (HASH_BYTES) entry_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic void flush_buffer(int cut);
      for (int i = 0; i <= cut; i++) begin
         push_word(entry_bytes[i], i == cut);
      end
      entry_bytes.delete();
   endfunction

   function automatic void add_random_buffer();
      int pick;
      int bad;
      pick = $urandom_range(0, 99);
      entry_bytes.delete();
      if (pick < 80) begin
         repeat ($urandom_range(1, 3)) add_entry();
         if (pick < 60) begin
            flush_buffer(entry_bytes.size() - 1);
         end else begin
            flush_buffer($urandom_range(0, entry_bytes.size() - 2));
         end
      end else if (pick < 92) begin
         repeat ($urandom_range(0, 3)) entry_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 7)));
         do begin
            bad = $urandom_range(0, 255);
         end while ((bad >= CHAR_ZERO && bad <= CHAR_SEVEN) || bad == CHAR_SPACE);
         entry_bytes.push_back(8'(bad));
         repeat ($urandom_range(0, 4)) entry_bytes.push_back(8'($urandom_range(0, 255)));
         flush_buffer(entry_bytes.size() - 1);
      end else begin
         repeat ($urandom_range(1, 6)) entry_bytes.push_back(8'($urandom_range(0, 255)));
         flush_buffer(entry_bytes.size() - 1);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         restart_parse();
      end else begin
         if (req_valid && req_ready) begin
            parse_byte(req_data);
            words_taken++;
         end
         if (!req_valid || req_ready) begin
            if (byte_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= byte_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               $error("result word of kind %0d arrived with nothing expected", rsp_data.kind);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               check_result(want, rsp_data);
               if (want.kind == KIND_ERROR) begin
                  errors_seen++;
               end
               if (want.entry_done) begin
                  entries_done++;
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Each short buffer below ends inside a different part of an entry.
      push_word(CHAR_SEVEN, 1'b1);
      push_word(8'hFF, 1'b1);
      push_word(CHAR_ZERO + 8'd1, 1'b0);
      push_word(8'h00, 1'b0);
      push_word(8'hFF, 1'b0);
      push_word(CHAR_SPACE, 1'b1);
      push_word(CHAR_SPACE, 1'b1);
      push_word(CHAR_SPACE, 1'b0);
      push_word(8'hFF, 1'b1);
      push_word(CHAR_SPACE, 1'b0);
      push_word(NAME_END_BYTE, 1'b1);
      push_word(CHAR_SPACE, 1'b0);
      push_word(8'h41, 1'b0);
      push_word(NAME_END_BYTE, 1'b0);
      push_word(8'h00, 1'b0);
      push_word(8'hFF, 1'b1);

      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = (p == 1) ? 46 : (p == 3) ? 15 : 0;
         recv_stall_pct = (p == 2) ? 46 : (p == 3) ? 15 : 0;
         while (words_queued < WORD_TARGET * (p + 1) / 4) begin
            add_random_buffer();
         end
         while (byte_queue.size() > 0) @(posedge clock);
      end

      while (expected_results.size() > 0 || req_valid) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Run fed %0d words from well-formed, cut-short and malformed buffers",
               words_taken);
      $display("under four pacing mixes; %0d results checked, %0d entries closed, %0d errors.",
               results_seen, entries_done, errors_seen);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/tesp_pkg.sv
rtl/tesp_step.sv
rtl/tree_entry_stream_parser.sv
verif/testbench.sv
